@@ src/drs_pkg.sv @@
package drs_pkg;

  localparam int NST = 89;
  localparam int IN_W = 136;
  localparam int OUT_W = 48;
  localparam int IDX_W = 15;

  localparam logic [14:0] IDX_MIN = 15'd4096;
  localparam logic [14:0] IDX_MAX = 15'd16384;
  localparam logic [14:0] IDX_RST = 15'd6144;
  localparam logic [57:0] ONE52 = 58'd1 << 52;
  localparam logic [28:0] ONE28 = 29'd1 << 28;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LD_INV = 7'b0000010,
    ST_DV_INV = 7'b0000100,
    ST_LD_R0B = 7'b0001000,
    ST_DV_R0B = 7'b0010000,
    ST_LD_R0F = 7'b0100000,
    ST_DV_R0F = 7'b1000000
  } cst_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat1(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) begin
      r = 16'sd16384;
    end else if (v < -64'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step(input sq_t a, input int unsigned b);
    logic [63:0] trial;
    sq_t r;
    trial = ({32'd0, a.root} << (b + 1)) | (64'd1 << (2 * b));
    r = a;
    if (a.rem >= trial) begin
      r.rem = a.rem - trial;
      r.root = a.root | (32'd1 << b);
    end
    return r;
  endfunction

endpackage

@@ src/dielectric_refract_scatter_top.sv @@
// Channel  Direction  Transaction
// cfg      in         refractive index, unsigned Q3.12
// in       in         one ray hit: direction, normal, random fraction, front-face flag
// out      out        scattered unit direction and reflected flag
//
// One transaction is accepted per cycle while in_tready is high.
// After reset and after every configuration write, a sequential divider works out
// the inverse index and both reflectances at normal incidence; in_tready stays low
// until it is done. A stall on the output halts the whole pipeline.
module dielectric_refract_scatter_top
  import drs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, random_value
  input  logic [IN_W-1:0]   in_tdata,
  // front_face
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // dir_x, dir_y, dir_z
  output logic [OUT_W-1:0]  out_tdata,
  // was_reflected
  output logic              out_tuser
);

  typedef struct {
    logic signed [23:0] d [3];
    logic signed [15:0] n [3];
    logic [15:0]        rnd;
    logic [14:0]        ri;
    logic [28:0]        ri_sq;
    logic [15:0]        r0;
    logic [47:0]        p [3];
    sq_t                sq;
    logic [45:0]        dn [3];
    logic [32:0]        drem [3];
    logic [15:0]        q [3];
    logic signed [15:0] u [3];
    logic signed [31:0] pu [3];
    logic signed [31:0] riu [3];
    logic signed [15:0] cs;
    logic [28:0]        cs2;
    logic [15:0]        x;
    logic [30:0]        xx;
    logic signed [31:0] rics;
    logic signed [31:0] cn [3];
    logic signed [15:0] ro [3];
    logic [28:0]        s2;
    sq_t                sn;
    logic [57:0]        t;
    sq_t                kq;
    logic [16:0]        x2;
    logic [33:0]        xx2;
    logic [18:0]        x4;
    logic [34:0]        x4x;
    logic [19:0]        x5;
    logic [36:0]        rp;
    logic               fres;
    logic               refl;
    logic signed [31:0] m;
    logic signed [47:0] mn [3];
    logic signed [47:0] v [3];
    logic signed [15:0] o [3];
  } item_t;

  function automatic item_t stage_fn(input item_t a, input int s);
    item_t r;
    logic [49:0] sq50;
    logic [23:0] mag;
    logic [32:0] rs;
    logic [15:0] qs;
    logic signed [33:0] dot;
    logic signed [31:0] c2;
    logic [52:0] k;
    int i;
    r = a;
    if (s == 1) begin
      sq50 = 50'(a.p[0]) + 50'(a.p[1]) + 50'(a.p[2]);
      r.sq.rem = 64'(sq50) << 16;
      r.sq.root = '0;
    end
    if (s >= 2 && s <= 33) begin
      r.sq = sqrt_step(a.sq, 33 - s);
    end
    if (s == 34) begin
      for (i = 0; i < 3; i++) begin
        mag = a.d[i][23] ? 24'(-a.d[i]) : 24'(a.d[i]);
        r.dn[i] = (46'(mag) << 22) + 46'(a.sq.root >> 1);
        r.drem[i] = 33'(r.dn[i] >> 16);
        r.q[i] = '0;
      end
    end
    if (s >= 35 && s <= 50) begin
      for (i = 0; i < 3; i++) begin
        rs = {a.drem[i][31:0], a.dn[i][50 - s]};
        if (rs >= {1'b0, a.sq.root}) begin
          r.drem[i] = rs - {1'b0, a.sq.root};
          r.q[i][50 - s] = 1'b1;
        end else begin
          r.drem[i] = rs;
        end
      end
    end
    if (s == 51) begin
      for (i = 0; i < 3; i++) begin
        qs = (a.q[i] > 16'd16384) ? 16'd16384 : a.q[i];
        if (a.sq.root == '0) begin
          r.u[i] = '0;
        end else begin
          r.u[i] = a.d[i][23] ? -$signed(qs) : $signed(qs);
        end
      end
    end
    if (s == 52) begin
      for (i = 0; i < 3; i++) begin
        r.pu[i] = a.u[i] * a.n[i];
        r.riu[i] = $signed({1'b0, a.ri}) * a.u[i];
      end
    end
    if (s == 53) begin
      dot = 34'(a.pu[0]) + 34'(a.pu[1]) + 34'(a.pu[2]);
      r.cs = sat1(-rshr(64'(dot), 14));
    end
    if (s == 54) begin
      c2 = a.cs * a.cs;
      r.cs2 = 29'(c2);
      r.x = 16'(17'sd16384 - 17'(a.cs));
      r.xx = r.x * r.x;
      r.rics = $signed({1'b0, a.ri}) * a.cs;
      for (i = 0; i < 3; i++) begin
        r.cn[i] = a.cs * a.n[i];
      end
    end
    if (s == 55) begin
      r.s2 = ONE28 - a.cs2;
      r.x2 = 17'((a.xx + 31'd8192) >> 14);
      r.sn.rem = 64'(r.s2);
      r.sn.root = '0;
      for (i = 0; i < 3; i++) begin
        r.ro[i] = sat1(64'(a.u[i]) + rshr(64'(a.cn[i]) <<< 1, 14));
      end
    end
    if (s == 56) begin
      r.t = a.ri_sq * a.s2;
      r.xx2 = a.x2 * a.x2;
    end
    if (s >= 56 && s <= 70) begin
      r.sn = sqrt_step(a.sn, 70 - s);
    end
    if (s == 57) begin
      k = (a.t > ONE52) ? '0 : 53'(ONE52 - a.t);
      r.kq.rem = 64'(k);
      r.kq.root = '0;
      r.x4 = 19'((a.xx2 + 34'd8192) >> 14);
    end
    if (s >= 58 && s <= 84) begin
      r.kq = sqrt_step(a.kq, 84 - s);
    end
    if (s == 58) begin
      r.x4x = a.x4 * a.x;
    end
    if (s == 59) begin
      r.x5 = 20'((a.x4x + 35'd8192) >> 14);
    end
    if (s == 60) begin
      r.rp = (17'h10000 - 17'(a.r0)) * a.x5;
    end
    if (s == 61) begin
      r.fres = (22'(a.r0) + 22'((a.rp + 37'd8192) >> 14)) > 22'(a.rnd);
    end
    if (s == 71) begin
      r.refl = a.fres || (({17'd0, a.ri} * a.sn.root) > 32'h0400_0000);
    end
    if (s == 85) begin
      r.m = 32'($signed({1'b0, a.kq.root}) - a.rics);
    end
    if (s == 86) begin
      for (i = 0; i < 3; i++) begin
        r.mn[i] = a.m * a.n[i];
      end
    end
    if (s == 87) begin
      for (i = 0; i < 3; i++) begin
        r.v[i] = (48'(a.riu[i]) <<< 14) - a.mn[i];
      end
    end
    if (s == 88) begin
      for (i = 0; i < 3; i++) begin
        r.o[i] = a.refl ? a.ro[i] : sat1(rshr(64'(a.v[i]), 40));
      end
    end
    return r;
  endfunction

  cst_t        state_r, state_nxt;
  logic [14:0] eta_r, eta_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [29:0] dvs_r, dvs_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [14:0] ri_f_r, ri_f_nxt;
  logic [15:0] r0b_r, r0b_nxt;
  logic [15:0] r0f_r, r0f_nxt;
  logic [28:0] rsq_b_r, rsq_b_nxt;
  logic [28:0] rsq_f_r, rsq_f_nxt;

  logic [14:0] eta_c;
  logic [14:0] ld_ri;
  logic [14:0] num;
  logic [14:0] den;
  logic [27:0] numsq;
  logic [28:0] densq;
  logic [30:0] rs;
  logic        ge;
  logic [30:0] rem_step;
  logic [47:0] quo_step;

  item_t pipe_r [NST];
  item_t pipe_nxt [NST];
  logic [NST-1:0] v_r, v_nxt;
  logic en;

  assign eta_c = (eta_r < IDX_MIN) ? IDX_MIN : ((eta_r > IDX_MAX) ? IDX_MAX : eta_r);
  assign ld_ri = (state_r == ST_LD_R0F) ? ri_f_r : eta_c;
  assign num = (ld_ri > IDX_MIN) ? ld_ri - IDX_MIN : IDX_MIN - ld_ri;
  assign den = IDX_MIN + ld_ri;
  assign numsq = num * num;
  assign densq = den * den;
  assign rs = {rem_r[29:0], dvd_r[47]};
  assign ge = rs >= {1'b0, dvs_r};
  assign rem_step = ge ? rs - {1'b0, dvs_r} : rs;
  assign quo_step = {quo_r[46:0], ge};
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    eta_nxt = eta_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    ri_f_nxt = ri_f_r;
    r0b_nxt = r0b_r;
    r0f_nxt = r0f_r;
    rsq_b_nxt = rsq_b_r;
    rsq_f_nxt = rsq_f_r;
    case (state_r)
      ST_LD_INV: begin
        dvd_nxt = 48'(25'd1 << 24) + 48'(eta_c >> 1);
        dvs_nxt = 30'(eta_c);
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        state_nxt = ST_DV_INV;
      end
      ST_LD_R0B, ST_LD_R0F: begin
        dvd_nxt = {4'd0, numsq, 16'd0} + 48'(densq >> 1);
        dvs_nxt = 30'(densq);
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        if (state_r == ST_LD_R0B) begin
          rsq_b_nxt = ld_ri * ld_ri;
          state_nxt = ST_DV_R0B;
        end else begin
          rsq_f_nxt = ld_ri * ld_ri;
          state_nxt = ST_DV_R0F;
        end
      end
      ST_DV_INV, ST_DV_R0B, ST_DV_R0F: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          if (state_r == ST_DV_INV) begin
            ri_f_nxt = quo_step[14:0];
            state_nxt = ST_LD_R0B;
          end else if (state_r == ST_DV_R0B) begin
            r0b_nxt = quo_step[15:0];
            state_nxt = ST_LD_R0F;
          end else begin
            r0f_nxt = quo_step[15:0];
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    if (cfg_valid) begin
      eta_nxt = cfg_data;
      state_nxt = ST_LD_INV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LD_INV;
      eta_r <= IDX_RST;
    end else begin
      state_r <= state_nxt;
      eta_r <= eta_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    ri_f_r <= ri_f_nxt;
    r0b_r <= r0b_nxt;
    r0f_r <= r0f_nxt;
    rsq_b_r <= rsq_b_nxt;
    rsq_f_r <= rsq_f_nxt;
  end

  assign en = !(v_r[NST-1] && !out_tready);
  assign in_tready = en && (state_r == ST_IDLE);

  always_comb begin
    item_t it;
    it = '{default: '0};
    it.d[0] = $signed(in_tdata[23:0]);
    it.d[1] = $signed(in_tdata[47:24]);
    it.d[2] = $signed(in_tdata[71:48]);
    it.n[0] = $signed(in_tdata[87:72]);
    it.n[1] = $signed(in_tdata[103:88]);
    it.n[2] = $signed(in_tdata[119:104]);
    it.rnd = in_tdata[135:120];
    it.ri = in_tuser ? ri_f_r : eta_c;
    it.ri_sq = in_tuser ? rsq_f_r : rsq_b_r;
    it.r0 = in_tuser ? r0f_r : r0b_r;
    for (int i = 0; i < 3; i++) begin
      it.p[i] = 48'(it.d[i]) * 48'(it.d[i]);
    end
    pipe_nxt[0] = it;
    v_nxt[0] = in_tvalid && in_tready;
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    always_comb begin
      pipe_nxt[g] = stage_fn(pipe_r[g-1], g);
      v_nxt[g] = v_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata = {pipe_r[NST-1].o[2], pipe_r[NST-1].o[1], pipe_r[NST-1].o[0]};
  assign out_tuser = pipe_r[NST-1].refl;

`ifndef SYNTHESIS
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[NST-2] |=> out_tvalid)
    else $error("pipeline lost a transaction");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input accepted while index constants were stale");
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384)
      && ($signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("output direction out of range");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import drs_pkg::*;

  localparam int LIMIT = 600000;

  typedef struct {
    logic [IN_W-1:0] td;
    logic            ff;
  } hit_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        refl;
  } scatter_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_data;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;

  hit_t     pending_hits[$];
  scatter_t expected_scatter[$];
  logic [14:0] index_reg;
  int  mismatches = 0;
  int  checked = 0;
  int  reflected_seen = 0;
  int  refracted_seen = 0;
  int  cycles = 0;
  int  burst_left;
  int  gap_left;
  int  stall_pct;
  int  long_hold_req;
  int  long_hold_seen;
  int  long_hold_left;
  bit  hold_send;

  dielectric_refract_scatter_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic scatter_t scatter_hit(input hit_t h, input logic [14:0] idx);
    longint eta, ri, len, dot, cs, s2, sn, num, den, r0, x, x2, x4, x5, rr, t, k, m, q;
    longint d[3];
    longint n[3];
    longint u[3];
    longint o[3];
    logic [63:0] sq;
    logic refl;
    scatter_t res;
    eta = idx;
    if (eta < 4096) eta = 4096;
    if (eta > 16384) eta = 16384;
    ri = h.ff ? ((longint'(1) <<< 24) + eta / 2) / eta : eta;
    sq = 64'd0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(h.td[i*24 +: 24]));
      n[i] = longint'($signed(h.td[72 + i*16 +: 16]));
      sq = sq + 64'(d[i] * d[i]);
    end
    len = longint'(int_sqrt(sq << 16));
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        q = ((((d[i] < 0) ? -d[i] : d[i]) <<< 22) + len / 2) / len;
        if (q > 16384) q = 16384;
        u[i] = (d[i] < 0) ? -q : q;
      end
      dot += u[i] * n[i];
    end
    cs = clamp_unit(-round_shift(dot, 14));
    s2 = (longint'(1) <<< 28) - cs * cs;
    sn = longint'(int_sqrt(64'(s2)));
    num = (ri > 4096) ? ri - 4096 : 4096 - ri;
    den = 4096 + ri;
    r0 = (num * num * 65536 + den * den / 2) / (den * den);
    x = 16384 - cs;
    x2 = (x * x + 8192) >>> 14;
    x4 = (x2 * x2 + 8192) >>> 14;
    x5 = (x4 * x + 8192) >>> 14;
    rr = r0 + (((65536 - r0) * x5 + 8192) >>> 14);
    refl = (ri * sn > (longint'(1) <<< 26)) || (rr > longint'(h.td[135:120]));
    if (refl) begin
      for (int i = 0; i < 3; i++) o[i] = clamp_unit(u[i] + round_shift(2 * cs * n[i], 14));
    end else begin
      t = ri * ri * s2;
      k = (t > (longint'(1) <<< 52)) ? 0 : (longint'(1) <<< 52) - t;
      m = longint'(int_sqrt(64'(k))) - ri * cs;
      for (int i = 0; i < 3; i++)
        o[i] = clamp_unit(round_shift(ri * u[i] * 16384 - m * n[i], 40));
    end
    res.x = o[0][15:0];
    res.y = o[1][15:0];
    res.z = o[2][15:0];
    res.refl = refl;
    return res;
  endfunction

  task automatic add_hit(input int dx, input int dy, input int dz, input int nx,
                         input int ny, input int nz, input bit ff, input int rv);
    hit_t h;
    h.td = {rv[15:0], nz[15:0], ny[15:0], nx[15:0], dz[23:0], dy[23:0], dx[23:0]};
    h.ff = ff;
    pending_hits.push_back(h);
  endtask

  task automatic add_random_hits(input int count);
    real vx, vy, vz, l;
    int sh;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_hit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1), $urandom);
      end else begin
        vx = real'($urandom_range(0, 2000)) - 1000.0;
        vy = real'($urandom_range(0, 2000)) - 1000.0;
        vz = real'($urandom_range(0, 2000)) - 1000.0;
        l = $sqrt(vx * vx + vy * vy + vz * vz);
        if (l < 1.0) begin
          vx = 0.0;
          vy = 0.0;
          vz = 1.0;
          l = 1.0;
        end
        sh = $urandom_range(0, 8);
        add_hit($signed(16'($urandom)) <<< sh, $signed(16'($urandom)) <<< sh,
                $signed(16'($urandom)) <<< sh,
                $rtoi(vx / l * 16384.0), $rtoi(vy / l * 16384.0), $rtoi(vz / l * 16384.0),
                $urandom_range(0, 1), $urandom_range(0, 65535));
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_hits.size() != 0 || expected_scatter.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_index(input logic [14:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    index_reg = v;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid)
        expected_scatter.push_back(scatter_hit(hit_t'{td: in_tdata, ff: in_tuser},
                                               index_reg));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_hits.size() != 0 && !hold_send) begin
        hit_t h;
        h = pending_hits.pop_front();
        in_tdata <= h.td;
        in_tuser <= h.ff;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      long_hold_seen <= 0;
      long_hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        scatter_t e;
        if (expected_scatter.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
        end else begin
          e = expected_scatter.pop_front();
          checked++;
          if (e.refl) reflected_seen++;
          else refracted_seen++;
          if (out_tdata[15:0] !== e.x || out_tdata[31:16] !== e.y ||
              out_tdata[47:32] !== e.z || out_tuser !== e.refl) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %h refl %b, got %h %h %h refl %b",
                       e.x, e.y, e.z, e.refl, out_tdata[15:0], out_tdata[31:16],
                       out_tdata[47:32], out_tuser);
          end
        end
      end
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen <= long_hold_req;
        long_hold_left <= 400;
        out_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
        long_hold_left <= long_hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [14:0] settings[6];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    index_reg = IDX_RST;
    stall_pct = 0;
    long_hold_req = 0;
    hold_send = 1'b0;
    settings = '{15'd4096, 15'd16384, 15'd0, 15'd32767,
                 15'($urandom_range(4096, 16384)), 15'($urandom)};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero direction, field extremes, grazing and head-on hits.
    add_hit(0, 0, 0, 0, 0, 16384, 1, 0);
    add_hit(0, 0, 0, 0, 16384, 0, 0, 65535);
    add_hit(0, 0, -8388608, 0, 0, 16384, 1, 65535);
    add_hit(0, 0, 8388607, 0, 0, 16384, 0, 0);
    add_hit(0, 0, -4096, 0, 0, 16384, 1, 65535);
    add_hit(0, 0, 4096, 0, 0, -16384, 0, 65535);
    add_hit(-8388608, -8388608, -8388608, 9459, 9459, 9459, 1, 32768);
    add_hit(8388607, 8388607, 8388607, -9459, -9459, -9459, 0, 32768);
    add_hit(4096, 0, -1, 0, 0, 16384, 1, 65535);
    add_hit(4096, 0, 1, 0, 0, -16384, 0, 65535);
    add_hit(4096, 0, -2000, 0, 0, 16384, 0, 65535);
    add_hit(4096, 0, -4096, 0, 0, 16384, 0, 65535);
    add_hit(4096, 4096, -4096, 11585, 0, 11585, 1, 100);
    add_hit(1, -1, 1, -16384, 16384, -16384, 1, 40000);
    add_hit(100, 200, -300, 32767, -32768, 32767, 0, 12345);
    add_hit(-5000, 300, 9000, -32768, 0, 0, 1, 65535);
    add_hit(8388607, -8388608, 0, 0, 0, 0, 1, 0);
    add_hit(1, 0, 0, -16384, 0, 0, 1, 65535);
    add_hit(-1, 0, 0, -16384, 0, 0, 0, 65535);
    add_hit(3000, -2000, -7000, 0, 16384, 0, 1, 30000);
    add_random_hits(280);
    wait_idle();

    foreach (settings[p]) begin
      write_index(settings[p]);
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      add_random_hits(200);
      if (p == 1) long_hold_req = long_hold_req + 1;
      if (p == 2) begin
        while (pending_hits.size() > 100) @(posedge clk);
        hold_send = 1'b1;
        @(negedge clk);
        while (expected_scatter.size() != 0 || in_tvalid) @(negedge clk);
        hold_send = 1'b0;
      end
      wait_idle();
    end

    $display("Checked %0d scatter results (%0d reflected, %0d refracted) over %0d index settings.",
             checked, reflected_seen, refracted_seen, 7);
    if (mismatches == 0 && expected_scatter.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("Mismatches: %0d, results still awaited: %0d.", mismatches,
               expected_scatter.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/drs_pkg.sv
src/dielectric_refract_scatter_top.sv
tb/sv/testbench.sv
